// ===== rtl/sorted_insert_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted insert priority queue
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SIPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIPQ_ASSERT_IMP(label, ante, cons, msg)
`define SIPQ_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/sipq_pkg.sv =====
// ----------------------------------------------------------------------------
// sipq_pkg
// Item types and result codes shared by the sorted insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int PRI_W    = 8;
    localparam int TAG_IN_W = 16;
    localparam int POS_W    = 7;

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        RES_ACCEPT = 2'd0,
        RES_DROP   = 2'd1,
        RES_ENTRY  = 2'd2,
        RES_EMPTY  = 2'd3
    } status_t;

    typedef struct packed
    {
        func_t                func;
        logic [PRI_W-1:0]     priority_req;
        logic [TAG_IN_W-1:0]  tag;
    } req_t;

    typedef struct packed
    {
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [PRI_W-1:0]     entry_priority;
        logic [TAG_IN_W-1:0]  entry_tag;
        logic                 last;
    } rsp_t;

endpackage

// ===== rtl/sorted_insert_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue held in ascending priority order in a slot memory.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction | payload
//  --------+--------------------------+-----------+---------------------------
//  request | req_valid, req_stall     | in        | req  (func, priority, tag)
//  result  | rsp_valid, rsp_stall     | out       | rsp  (status .. last)
//
//  Insert: the scan compares one slot a cycle from the top, moving each larger
//  entry up one slot. A full-queue insert skips the scan and gives RES_DROP.
//  Readout: one result a cycle while not stalled; an empty one gives RES_EMPTY.
//  One item at a time; req_stall is high until the last result is registered.
//  rsp_stall holds the result register and pauses the readout in place.
//  Reset clears state, occupancy, count and rsp_valid; slot contents need none.
// ----------------------------------------------------------------------------
`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sipq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sipq_pkg::rsp_t rsp
);

    localparam int OCC_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int STORE_W = (TAG_BITS < sipq_pkg::TAG_IN_W) ? TAG_BITS
                                                              : sipq_pkg::TAG_IN_W;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PUT   = 5'b00100,
        S_RESP  = 5'b01000,
        S_RDOUT = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic [OCC_W-1:0]             cnt_reg, cnt_next;
    logic [sipq_pkg::PRI_W-1:0]   pri_reg, pri_next;
    logic [STORE_W-1:0]           tag_reg, tag_next;
    sipq_pkg::status_t            code_reg, code_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    sipq_pkg::rsp_t               rsp_reg, rsp_next;

    logic [sipq_pkg::PRI_W-1:0]   pri_mem [CAPACITY];
    logic [STORE_W-1:0]           tag_mem [CAPACITY];
    logic [sipq_pkg::PRI_W-1:0]   rd_pri_reg;
    logic [STORE_W-1:0]           rd_tag_reg;
    logic [OCC_W-1:0]             rd_idx;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         wr_en;
    logic [sipq_pkg::PRI_W-1:0]   wr_pri;
    logic [STORE_W-1:0]           wr_tag;

    logic                         out_free;
    logic [OCC_W-1:0]             cnt_inc;
    logic                         full;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cnt_inc   = cnt_reg + OCC_W'(1);
    assign full      = (occ_reg == OCC_W'(CAPACITY));
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // read address follows the next counter so the data lines up a cycle on
    assign rd_idx  = (state_next == S_RDOUT) ? cnt_next : cnt_next - OCC_W'(1);
    assign rd_addr = rd_idx[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        pri_next       = pri_reg;
        tag_next       = tag_reg;
        code_next      = code_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_pri         = rd_pri_reg;
        wr_tag         = rd_tag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pri_next = req.priority_req;
                    tag_next = req.tag[STORE_W-1:0];
                    if (req.func == sipq_pkg::FUNC_INSERT)
                    begin
                        cnt_next = occ_reg;
                        if (full)
                        begin
                            code_next  = sipq_pkg::RES_DROP;
                            state_next = S_RESP;
                        end
                        else if (occ_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        cnt_next = '0;
                        if (occ_reg == '0)
                        begin
                            code_next  = sipq_pkg::RES_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_RDOUT;
                        end
                    end
                end
            end

            // read data holds slot cnt-1; larger entries move up one slot
            S_SCAN:
            begin
                if (rd_pri_reg > pri_reg)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg - OCC_W'(1);
                    if (cnt_reg == OCC_W'(1))
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_pri     = pri_reg;
                wr_tag     = tag_reg;
                occ_next   = occ_reg + OCC_W'(1);
                code_next  = sipq_pkg::RES_ACCEPT;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = code_reg;
                    rsp_next.position       = '0;
                    rsp_next.entry_priority = '0;
                    rsp_next.entry_tag      = '0;
                    rsp_next.last           = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            S_RDOUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = sipq_pkg::RES_ENTRY;
                    rsp_next.position       = sipq_pkg::POS_W'(cnt_inc);
                    rsp_next.entry_priority = rd_pri_reg;
                    rsp_next.entry_tag      = sipq_pkg::TAG_IN_W'(rd_tag_reg);
                    rsp_next.last           = (cnt_inc == occ_reg);
                    cnt_next                = cnt_inc;
                    if (cnt_inc == occ_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg  <= pri_next;
        tag_reg  <= tag_next;
        code_reg <= code_next;
        rsp_reg  <= rsp_next;
    end

    // slot memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pri_mem[cnt_reg[ADDR_W-1:0]] <= wr_pri;
            tag_mem[cnt_reg[ADDR_W-1:0]] <= wr_tag;
        end
        rd_pri_reg <= pri_mem[rd_addr];
        rd_tag_reg <= tag_mem[rd_addr];
    end

    `SIPQ_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= OCC_W'(CAPACITY), "occupancy over capacity")
    `SIPQ_ASSERT_IMP(a_scan_cnt, state_reg == S_SCAN, cnt_reg != '0, "scan below slot zero")
    `SIPQ_ASSERT_NXT(a_occ_step, state_reg != S_PUT, $stable(occ_reg), "occupancy moved off put")
    `SIPQ_ASSERT_IMP(a_pos_range,
                     rsp_valid && rsp.status == sipq_pkg::RES_ENTRY,
                     rsp.position != '0 && rsp.position <= sipq_pkg::POS_W'(occ_reg),
                     "readout position out of range")

endmodule
